[hdl/twq_pkg.sv]
package twq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int TIME_W     = 48;
    localparam int SEQ_W      = 16;
    localparam int POS_W      = 32;
    localparam int WOFS_W     = 32;
    localparam int ERR_W      = 8;
    localparam int TIMEOUT_W  = 32;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TIMEOUT_W-1:0] STARVE_RESET = 32'd500000;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_EXEC  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_ESTOP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ACT_RUN     = 2'd0,
        ACT_CANCEL  = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_UNKNOWN = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_DRIVE  = 2'd1,
        KIND_REPORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RSN_REACHED   = 2'd0,
        RSN_DONE      = 2'd1,
        RSN_CANCELLED = 2'd2,
        RSN_FAULT     = 2'd3
    } reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_OFFSET    = 1'b0,
        CFG_STARVE_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_RUN    = 3'd1,
        OP_CANCEL = 3'd2,
        OP_FLUSH  = 3'd3,
        OP_REJECT = 3'd4,
        OP_TICK   = 3'd5,
        OP_ESTOP  = 3'd6,
        OP_DRVERR = 3'd7
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [TIME_W-1:0]        now_us;
        logic [SEQ_W-1:0]         wp_seq;
        logic signed [POS_W-1:0]  wp_position;
        logic [WOFS_W-1:0]        wp_time_offset_us;
        logic                     wp_inpos;
        logic                     buffered;
        logic [TIME_W-1:0]        start_time_us;
        logic [ERR_W-1:0]         drv_error_code;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0]         seq;
        logic signed [POS_W-1:0]  position;
        logic [WOFS_W-1:0]        offset;
        logic                     inpos;
    } entry_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     accepted;
        logic signed [POS_W-1:0]  position;
        reason_t                  reason;
        logic [SEQ_W-1:0]         seq;
        logic [ERR_W-1:0]         error_code;
        logic                     stop_motor;
        logic                     last_of_run;
    } res_t;

endpackage

[hdl/timed_waypoint_queue_unit.sv]
// Timed waypoint queue for a motor driver. Requests enter a two-entry command queue, which
// goes on taking beats while it has room, also while the execution side is busy or a result
// waits to be taken. The execution side handles one command at a time: it takes the command
// and reads the queue head from the waypoint memory in the same cycle, executes in the next,
// and offers the first result beat from an output register in the cycle after that, holding
// each beat while the output is stalled. A command gives one result beat, two when a released
// waypoint is marked in position (a drive beat, then a reached report), and a tick may give none.
// The registered memory read at the head is why execution has a state of its own. The waypoint
// memory needs no clearing after reset.
module timed_waypoint_queue_unit #(
    parameter int QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [twq_pkg::TIME_W-1:0]          now_us,
    input  logic [twq_pkg::SEQ_W-1:0]           wp_seq,
    input  logic signed [twq_pkg::POS_W-1:0]    wp_position,
    input  logic [twq_pkg::WOFS_W-1:0]          wp_time_offset_us,
    input  logic                                wp_inpos,
    input  logic                                buffered,
    input  logic [1:0]                          exec_action,
    input  logic [twq_pkg::TIME_W-1:0]          start_time_us,
    input  logic                                fault_line,
    input  logic                                drv_status_valid,
    input  logic [twq_pkg::ERR_W-1:0]           drv_error_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          res_kind,
    output logic                                accepted,
    output logic signed [twq_pkg::POS_W-1:0]    position,
    output logic [1:0]                          reason,
    output logic [twq_pkg::SEQ_W-1:0]           seq,
    output logic [twq_pkg::ERR_W-1:0]           error_code,
    output logic                                stop_motor,
    output logic                                last_of_run,
    input  logic                                cfg_we,
    input  logic [twq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic          cmd_valid;
    logic          cmd_take;
    twq_pkg::cmd_t cmd;
    twq_pkg::res_t out_res;

    twq_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .now_us            (now_us),
        .wp_seq            (wp_seq),
        .wp_position       (wp_position),
        .wp_time_offset_us (wp_time_offset_us),
        .wp_inpos          (wp_inpos),
        .buffered          (buffered),
        .exec_action       (exec_action),
        .start_time_us     (start_time_us),
        .fault_line        (fault_line),
        .drv_status_valid  (drv_status_valid),
        .drv_error_code    (drv_error_code),
        .cmd_valid         (cmd_valid),
        .cmd_take          (cmd_take),
        .cmd               (cmd)
    );

    twq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign res_kind    = out_res.kind;
    assign accepted    = out_res.accepted;
    assign position    = out_res.position;
    assign reason      = out_res.reason;
    assign seq         = out_res.seq;
    assign error_code  = out_res.error_code;
    assign stop_motor  = out_res.stop_motor;
    assign last_of_run = out_res.last_of_run;

    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty command queue");

    a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_take)
        else $error("second command taken while the first is executing");

    a_no_take_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd_take)
        else $error("command taken while a result beat is pending");

    a_beat_reaches_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd_valid)
        else $error("accepted input beat not visible to the execution side");

endmodule

[hdl/twq_ram.sv]
module twq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/twq_front.sv]
module twq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [twq_pkg::TIME_W-1:0]          now_us,
    input  logic [twq_pkg::SEQ_W-1:0]           wp_seq,
    input  logic signed [twq_pkg::POS_W-1:0]    wp_position,
    input  logic [twq_pkg::WOFS_W-1:0]          wp_time_offset_us,
    input  logic                                wp_inpos,
    input  logic                                buffered,
    input  logic [1:0]                          exec_action,
    input  logic [twq_pkg::TIME_W-1:0]          start_time_us,
    input  logic                                fault_line,
    input  logic                                drv_status_valid,
    input  logic [twq_pkg::ERR_W-1:0]           drv_error_code,
    output logic                                cmd_valid,
    input  logic                                cmd_take,
    output twq_pkg::cmd_t                       cmd
);

    twq_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    twq_pkg::op_t  op;
    logic          push;

    always_comb
    begin
        unique case (req_type)
            twq_pkg::REQ_PUSH:
            begin
                op = twq_pkg::OP_PUSH;
            end
            twq_pkg::REQ_EXEC:
            begin
                case (exec_action)
                    twq_pkg::ACT_RUN:    op = twq_pkg::OP_RUN;
                    twq_pkg::ACT_CANCEL: op = twq_pkg::OP_CANCEL;
                    twq_pkg::ACT_FLUSH:  op = twq_pkg::OP_FLUSH;
                    default:             op = twq_pkg::OP_REJECT;
                endcase
            end
            twq_pkg::REQ_TICK:
            begin
                if (fault_line)
                begin
                    op = twq_pkg::OP_ESTOP;
                end
                else if (drv_status_valid && (drv_error_code != '0))
                begin
                    op = twq_pkg::OP_DRVERR;
                end
                else
                begin
                    op = twq_pkg::OP_TICK;
                end
            end
            default:
            begin
                op = twq_pkg::OP_ESTOP;
            end
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{
                op:                op,
                now_us:            now_us,
                wp_seq:            wp_seq,
                wp_position:       wp_position,
                wp_time_offset_us: wp_time_offset_us,
                wp_inpos:          wp_inpos,
                buffered:          buffered,
                start_time_us:     start_time_us,
                drv_error_code:    drv_error_code
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !cmd_take)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && cmd_take)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[hdl/twq_back.sv]
module twq_back #(
    parameter int QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_take,
    input  twq_pkg::cmd_t                        cmd,
    input  logic                                 cfg_we,
    input  logic [twq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twq_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output twq_pkg::res_t                        out_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = twq_pkg::TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEND
    } state_t;

    state_t                          state_reg, state_next;
    twq_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [PTR_W-1:0]                head_reg, head_next;
    logic [PTR_W-1:0]                tail_reg, tail_next;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic                            running_reg, running_next;
    logic [TW-1:0]                   start_reg, start_next;
    logic [TW-1:0]                   last_push_reg, last_push_next;
    logic                            starved_reg, starved_next;
    logic signed [twq_pkg::POS_W-1:0] last_pos_reg, last_pos_next;
    logic                            sent_any_reg, sent_any_next;
    logic [TW-1:0]                   offset_cfg_reg, offset_cfg_next;
    logic [twq_pkg::TIMEOUT_W-1:0]   timeout_cfg_reg, timeout_cfg_next;
    twq_pkg::res_t                   res0_reg, res0_next;
    twq_pkg::res_t                   res1_reg, res1_next;
    logic                            pend_reg, pend_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            ram_we;
    logic [$bits(twq_pkg::entry_t)-1:0] ram_rdata;
    twq_pkg::entry_t                 head_entry;
    twq_pkg::entry_t                 new_entry;
    logic [TW-1:0]                   master_now;
    logic [TW:0]                     due_at;
    logic [TW:0]                     push_gap;
    logic                            due;
    logic                            starve;
    logic [1:0]                      nres;

    assign cmd_take   = (state_reg == S_IDLE) && cmd_valid;
    assign head_entry = twq_pkg::entry_t'(ram_rdata);
    assign new_entry  = '{
        seq:      cmd_reg.wp_seq,
        position: cmd_reg.wp_position,
        offset:   cmd_reg.wp_time_offset_us,
        inpos:    cmd_reg.wp_inpos
    };

    twq_ram #(
        .WIDTH ($bits(twq_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (tail_reg),
        .wr_data (new_entry),
        .rd_en   (cmd_take),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    // Master time wraps at 48 bits; the due time is kept one bit wider so that it never wraps.
    assign master_now = cmd_reg.now_us + offset_cfg_reg;
    assign due_at     = {1'b0, start_reg} + {{(TW + 1 - twq_pkg::WOFS_W){1'b0}}, head_entry.offset};
    assign due        = running_reg && (fill_reg != '0) && ({1'b0, master_now} >= due_at);
    assign push_gap   = {1'b0, cmd_reg.now_us} - {1'b0, last_push_reg};
    assign starve     = sent_any_reg && !starved_reg && !push_gap[TW]
                        && (push_gap[TW-1:0] > {{(TW - twq_pkg::TIMEOUT_W){1'b0}}, timeout_cfg_reg});

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        running_next     = running_reg;
        start_next       = start_reg;
        last_push_next   = last_push_reg;
        starved_next     = starved_reg;
        last_pos_next    = last_pos_reg;
        sent_any_next    = sent_any_reg;
        offset_cfg_next  = offset_cfg_reg;
        timeout_cfg_next = timeout_cfg_reg;
        res0_next        = res0_reg;
        res1_next        = res1_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg;
        ram_we           = 1'b0;
        nres             = 2'd0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                twq_pkg::CFG_TIME_OFFSET:    offset_cfg_next  = cfg_data[TW-1:0];
                twq_pkg::CFG_STARVE_TIMEOUT: timeout_cfg_next = cfg_data[twq_pkg::TIMEOUT_W-1:0];
                default:                     offset_cfg_next  = offset_cfg_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res0_next = '0;
                res1_next = '0;
                res0_next.last_of_run = 1'b1;
                res1_next.last_of_run = 1'b1;
                unique case (cmd_reg.op)
                    twq_pkg::OP_PUSH:
                    begin
                        nres = 2'd1;
                        res0_next.kind = twq_pkg::KIND_ACK;
                        if (fill_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            ram_we    = 1'b1;
                            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                        : tail_reg + 1'b1;
                            fill_next      = fill_reg + 1'b1;
                            last_push_next = cmd_reg.now_us;
                            starved_next   = 1'b0;
                            if (!cmd_reg.buffered && !running_reg)
                            begin
                                running_next = 1'b1;
                                start_next   = master_now;
                            end
                            res0_next.accepted = 1'b1;
                        end
                    end
                    twq_pkg::OP_RUN:
                    begin
                        nres = 2'd1;
                        res0_next.kind = twq_pkg::KIND_ACK;
                        if (fill_reg != '0)
                        begin
                            running_next = 1'b1;
                            start_next   = (cmd_reg.start_time_us != '0) ? cmd_reg.start_time_us
                                           : master_now;
                            res0_next.accepted = 1'b1;
                        end
                    end
                    twq_pkg::OP_CANCEL:
                    begin
                        nres = 2'd1;
                        res0_next.kind     = twq_pkg::KIND_ACK;
                        res0_next.accepted = 1'b1;
                        head_next    = '0;
                        tail_next    = '0;
                        fill_next    = '0;
                        running_next = 1'b0;
                        start_next   = '0;
                    end
                    twq_pkg::OP_FLUSH:
                    begin
                        nres = 2'd1;
                        res0_next.kind     = twq_pkg::KIND_ACK;
                        res0_next.accepted = 1'b1;
                        head_next = '0;
                        tail_next = '0;
                        fill_next = '0;
                    end
                    twq_pkg::OP_REJECT:
                    begin
                        nres = 2'd1;
                        res0_next.kind = twq_pkg::KIND_ACK;
                    end
                    twq_pkg::OP_ESTOP:
                    begin
                        nres = 2'd1;
                        res0_next.kind       = twq_pkg::KIND_REPORT;
                        res0_next.position   = last_pos_reg;
                        res0_next.reason     = twq_pkg::RSN_CANCELLED;
                        res0_next.seq        = (fill_reg != '0) ? head_entry.seq : '0;
                        res0_next.stop_motor = 1'b1;
                        head_next    = '0;
                        tail_next    = '0;
                        fill_next    = '0;
                        running_next = 1'b0;
                        start_next   = '0;
                    end
                    twq_pkg::OP_DRVERR:
                    begin
                        nres = 2'd1;
                        res0_next.kind       = twq_pkg::KIND_REPORT;
                        res0_next.position   = last_pos_reg;
                        res0_next.reason     = twq_pkg::RSN_FAULT;
                        res0_next.error_code = cmd_reg.drv_error_code;
                        res0_next.stop_motor = 1'b1;
                        head_next    = '0;
                        tail_next    = '0;
                        fill_next    = '0;
                        running_next = 1'b0;
                        start_next   = '0;
                    end
                    twq_pkg::OP_TICK:
                    begin
                        if (due)
                        begin
                            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                        : head_reg + 1'b1;
                            fill_next     = fill_reg - 1'b1;
                            last_pos_next = head_entry.position;
                            sent_any_next = 1'b1;
                            res0_next.kind     = twq_pkg::KIND_DRIVE;
                            res0_next.position = head_entry.position;
                            res0_next.seq      = head_entry.seq;
                            res1_next.kind     = twq_pkg::KIND_REPORT;
                            res1_next.position = head_entry.position;
                            res1_next.reason   = twq_pkg::RSN_REACHED;
                            res1_next.seq      = head_entry.seq;
                            if (head_entry.inpos)
                            begin
                                nres = 2'd2;
                                res0_next.last_of_run = 1'b0;
                            end
                            else
                            begin
                                nres = 2'd1;
                            end
                        end
                        else if (running_reg && (fill_reg == '0))
                        begin
                            nres = 2'd1;
                            running_next = 1'b0;
                            res0_next.kind     = twq_pkg::KIND_REPORT;
                            res0_next.position = last_pos_reg;
                            res0_next.reason   = twq_pkg::RSN_DONE;
                        end
                        else if (starve)
                        begin
                            nres = 2'd1;
                            starved_next = 1'b1;
                            res0_next.kind       = twq_pkg::KIND_REPORT;
                            res0_next.position   = last_pos_reg;
                            res0_next.reason     = twq_pkg::RSN_FAULT;
                            res0_next.stop_motor = 1'b1;
                        end
                    end
                    default:
                    begin
                        nres = 2'd0;
                    end
                endcase
                if (nres == 2'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next     = S_SEND;
                    out_valid_next = 1'b1;
                    pend_next      = (nres == 2'd2);
                end
            end
            S_SEND:
            begin
                if (!out_stall)
                begin
                    if (pend_reg)
                    begin
                        res0_next = res1_reg;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            running_reg     <= 1'b0;
            start_reg       <= '0;
            last_push_reg   <= '0;
            starved_reg     <= 1'b0;
            last_pos_reg    <= '0;
            sent_any_reg    <= 1'b0;
            offset_cfg_reg  <= '0;
            timeout_cfg_reg <= twq_pkg::STARVE_RESET;
            res0_reg        <= '0;
            res1_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
            running_reg     <= running_next;
            start_reg       <= start_next;
            last_push_reg   <= last_push_next;
            starved_reg     <= starved_next;
            last_pos_reg    <= last_pos_next;
            sent_any_reg    <= sent_any_next;
            offset_cfg_reg  <= offset_cfg_next;
            timeout_cfg_reg <= timeout_cfg_next;
            res0_reg        <= res0_next;
            res1_reg        <= res1_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res0_reg;

endmodule
